// ===== hw/rtl/lzd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzd_pkg: shared types and constants of the lzss decoder
// Window geometry, parse phases, sequencer states and the history port group.
// ----------------------------------------------------------------------------
package lzd_pkg;

  // window and stream format
  localparam int WIN_SIZE  = 512;
  localparam int WIN_AW    = $clog2(WIN_SIZE);
  localparam int HDR_BYTES = 4;
  localparam int CNT_W     = 21;
  localparam int LEN_W     = 5;

  localparam logic [WIN_AW-1:0] WP_INIT   = WIN_AW'(WIN_SIZE - 18);
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [2:0]        HDR_INIT  = 3'(HDR_BYTES);
  localparam logic [LEN_W-1:0]  MIN_MATCH = LEN_W'(3);
  localparam logic [7:0]        FLAG_FILL = 8'hFF;

  // configuration register index
  localparam logic [0:0] REG_TOTAL = 1'b0;

  // parse phase of the packed stream
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_ITEM,
    PH_MATCH,
    PH_DONE
  } phase_t;

  // sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_PARSE,
    SQ_LIT,
    SQ_RD,
    SQ_WR
  } seq_t;

  // history window port group
  typedef struct packed {
    logic              clear;
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [WIN_AW-1:0] raddr;
  } hist_req_t;

  // result of the top-of-item check
  typedef struct packed {
    phase_t      ph;
    logic [15:0] flag;
  } item_t;

  // end check, then step to the next flag bit
  function automatic item_t next_item(input logic [CNT_W-1:0] cnt,
                                      input logic [CNT_W-1:0] total,
                                      input logic [15:0]      flag);
    item_t r;
    r.flag = flag;
    if (cnt >= total) begin
      r.ph = PH_DONE;
    end else begin
      r.flag = flag >> 1;
      r.ph   = r.flag[8] ? PH_ITEM : PH_FLAG;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lzd_cfg.sv =====
// ----------------------------------------------------------------------------
// lzd_cfg: configuration register file
// APB-style slave holding the output byte total; always ready.
// ----------------------------------------------------------------------------
module lzd_cfg
  import lzd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CNT_W-1:0] total
);

  logic [CNT_W-1:0] total_r;
  logic             hit;

  // register decode, low address bits are ignored and the whole word is returned
  assign hit    = (paddr[2:2] == REG_TOTAL) && (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00);
  assign pready = 1'b1;
  assign total  = total_r;
  assign prdata = hit ? {{(32-CNT_W){1'b0}}, total_r} : 32'd0;

  // write at the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (psel && penable && pwrite && pready && hit) begin
      total_r <= pwdata[CNT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/lzd_hist.sv =====
// ----------------------------------------------------------------------------
// lzd_hist: history window
// Single-port-write, registered-read byte memory. A fill count tracks how many
// positions have been written since the stream began; unwritten ones read 0.
// ----------------------------------------------------------------------------
module lzd_hist
  import lzd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hist_req_t req,
  output logic [7:0] rd_data
);

  logic [7:0]        mem [WIN_SIZE];
  logic [7:0]        rd_q;
  logic              rd_ok_r;
  logic [WIN_AW:0]   fill_r;
  logic [WIN_AW:0]   fill_nxt;
  logic [WIN_AW-1:0] rel_pos;

  // distance of the read position from the stream's first write position
  assign rel_pos = req.raddr - WP_INIT;

  // fill count, saturates once the whole window has been written
  always_comb begin
    fill_nxt = fill_r;
    if (req.clear) begin
      fill_nxt = '0;
    end else if (req.we && fill_r != (WIN_AW+1)'(WIN_SIZE)) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // memory array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q    <= mem[req.raddr];
    rd_ok_r <= ({1'b0, rel_pos} < fill_r);
  end

  assign rd_data = rd_ok_r ? rd_q : 8'd0;

endmodule

// ===== hw/rtl/lzss_decoder_512_window_top.sv =====
// ----------------------------------------------------------------------------
// lzss_decoder_512_window_top: lzss decoder with a 512-byte history window
// Parses header, flag, literal and match bytes and emits decoded bytes.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_start_of_stream, in_byte
//   out      output     out_valid/out_stall out_byte, out_last_of_run,
//                                          out_image_done
//   cfg      input      psel/penable/pready paddr, pwdata, prdata
//
// Each copied byte of a match is one read and one write of the window memory,
// in SQ_RD and then SQ_WR; a match copies 3 to 18 bytes.
// Reset leaves the decoder as if a stream had just started; the window is
// emptied by a fill count, so there is no clearing pass.
// A stalled result holds the sequencer; in_stall is high while a request works.
// ----------------------------------------------------------------------------
module lzss_decoder_512_window_top
  import lzd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_of_stream,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_image_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0] total;

  seq_t state_r, state_nxt;

  phase_t            ph_r, ph_nxt;
  logic [2:0]        hl_r, hl_nxt;
  logic [15:0]       flag_r, flag_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [7:0]        mf_r, mf_nxt;
  logic [WIN_AW-1:0] rp_r, rp_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [7:0]        byte_r;
  logic              sos_r;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_done_r, out_done_nxt;

  logic              go_lit, go_match;
  logic              out_free, emit, last_emit;
  logic [7:0]        emit_data;
  logic [CNT_W-1:0]  cnt_inc;
  logic [7:0]        hist_data;
  hist_req_t         hreq;

  logic [11:0]       raw_off;
  item_t             ni;

  // configuration registers
  lzd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .total   (total)
  );

  // history window
  lzd_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .rd_data (hist_data)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_IDLE:  if (in_valid) state_nxt = SQ_PARSE;
      SQ_PARSE: begin
        if (go_lit) state_nxt = SQ_LIT;
        else if (go_match) state_nxt = SQ_RD;
        else state_nxt = SQ_IDLE;
      end
      SQ_LIT:   if (out_free) state_nxt = SQ_IDLE;
      SQ_RD:    state_nxt = SQ_WR;
      SQ_WR:    if (out_free) state_nxt = (len_r == LEN_W'(1)) ? SQ_IDLE : SQ_RD;
      default:  state_nxt = SQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    emit      = 1'b0;
    last_emit = 1'b0;
    emit_data = byte_r;
    case (state_r)
      SQ_IDLE: in_stall = 1'b0;
      SQ_LIT: begin
        emit      = out_free;
        last_emit = 1'b1;
      end
      SQ_WR: begin
        emit      = out_free;
        last_emit = (len_r == LEN_W'(1));
        emit_data = hist_data;
      end
      default: in_stall = 1'b1;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign raw_off  = {byte_r[7:4], mf_r};

  // window port
  always_comb begin
    hreq.clear = (state_r == SQ_PARSE) && sos_r;
    hreq.we    = emit;
    hreq.waddr = wp_r;
    hreq.wdata = emit_data;
    hreq.raddr = rp_r;
  end

  // parse step and emission datapath
  always_comb begin
    ph_nxt   = ph_r;
    hl_nxt   = hl_r;
    flag_nxt = flag_r;
    cnt_nxt  = cnt_r;
    wp_nxt   = wp_r;
    mf_nxt   = mf_r;
    rp_nxt   = rp_r;
    len_nxt  = len_r;
    go_lit   = 1'b0;
    go_match = 1'b0;
    ni       = next_item(cnt_r, total, flag_r);

    if (state_r == SQ_PARSE) begin
      // start mark restarts the stream
      if (sos_r) begin
        ph_nxt   = PH_HEADER;
        hl_nxt   = HDR_INIT;
        flag_nxt = '0;
        cnt_nxt  = '0;
        wp_nxt   = WP_INIT;
        mf_nxt   = '0;
      end
      // empty header moves straight to the first item
      if (ph_nxt == PH_HEADER && hl_nxt == 3'd0) begin
        ni       = next_item(cnt_nxt, total, flag_nxt);
        ph_nxt   = ni.ph;
        flag_nxt = ni.flag;
      end
      case (ph_nxt)
        PH_HEADER: begin
          hl_nxt = hl_nxt - 3'd1;
          if (hl_nxt == 3'd0) begin
            ni       = next_item(cnt_nxt, total, flag_nxt);
            ph_nxt   = ni.ph;
            flag_nxt = ni.flag;
          end
        end
        PH_FLAG: begin
          flag_nxt = {FLAG_FILL, byte_r};
          ph_nxt   = PH_ITEM;
        end
        PH_ITEM: begin
          if (flag_nxt[0]) begin
            go_lit = 1'b1;
          end else begin
            mf_nxt = byte_r;
            ph_nxt = PH_MATCH;
          end
        end
        PH_MATCH: begin
          go_match = 1'b1;
          rp_nxt   = raw_off[WIN_AW-1:0];
          len_nxt  = {1'b0, byte_r[3:0]} + MIN_MATCH;
        end
        default: ph_nxt = PH_DONE;
      endcase
    end

    // one byte out: window write, count, then next item after the last byte
    if (emit) begin
      wp_nxt  = wp_r + 1'b1;
      cnt_nxt = cnt_inc;
      rp_nxt  = rp_r + 1'b1;
      len_nxt = len_r - 1'b1;
      if (last_emit) begin
        ni       = next_item(cnt_inc, total, flag_r);
        ph_nxt   = ni.ph;
        flag_nxt = ni.flag;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_data;
      out_last_nxt  = last_emit;
      out_done_nxt  = (cnt_inc >= total);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      ph_r        <= (HDR_INIT == 3'd0) ? PH_HEADER : PH_HEADER;
      hl_r        <= HDR_INIT;
      flag_r      <= '0;
      cnt_r       <= '0;
      wp_r        <= WP_INIT;
      mf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      hl_r        <= hl_nxt;
      flag_r      <= flag_nxt;
      cnt_r       <= cnt_nxt;
      wp_r        <= wp_nxt;
      mf_r        <= mf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == SQ_IDLE && in_valid) begin
      byte_r <= in_byte;
      sos_r  <= in_start_of_stream;
    end
    rp_r       <= rp_nxt;
    len_r      <= len_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_image_done  = out_done_r;

endmodule
